// ===== sv/dmts_pkg.sv =====
// Shared constants, codes and helpers for the disjoint mask tuple search unit.
`timescale 1ns / 1ps
`default_nettype none
package dmts_pkg;

  localparam int MAX_BLOCKS  = 16;
  localparam int MAX_OPTIONS = 64;
  localparam int MAX_WORDS   = 4;

  localparam int LVL_W   = $clog2(MAX_BLOCKS);
  localparam int OPT_W   = $clog2(MAX_OPTIONS);
  localparam int WRD_W   = $clog2(MAX_WORDS);
  localparam int CNT_W   = OPT_W + 1;
  localparam int NB_W    = LVL_W + 1;
  localparam int MASK_AW = LVL_W + OPT_W + WRD_W;
  localparam int PART_AW = LVL_W + WRD_W;

  typedef enum logic [1:0] {
    OP_LOAD_MASK  = 2'd0,
    OP_SET_COUNT  = 2'd1,
    OP_RUN        = 2'd2,
    OP_NONE       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FEASIBLE   = 2'd0,
    ST_INFEASIBLE = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  localparam logic [3:0] CFG_BLOCK_COUNT = 4'd0;
  localparam logic [3:0] CFG_WORD_COUNT  = 4'd1;

  // Clamp the block count register to the supported range
  function automatic logic [NB_W-1:0] eff_blocks(input logic [4:0] v);
    logic [NB_W-1:0] r;
    if (v < 5'd2) r = NB_W'(2);
    else if (int'(v) > MAX_BLOCKS) r = NB_W'(MAX_BLOCKS);
    else r = NB_W'(v);
    return r;
  endfunction

  // Clamp the word count register to the supported range
  function automatic logic [WRD_W:0] eff_words(input logic [2:0] v);
    logic [WRD_W:0] r;
    if (v < 3'd1) r = (WRD_W+1)'(1);
    else if (int'(v) > MAX_WORDS) r = (WRD_W+1)'(MAX_WORDS);
    else r = (WRD_W+1)'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/disjoint_mask_tuple_search_unit.sv =====
// Top level: item decode, depth-first search sequencer and result emission.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  input     | start / busy            | opcode, block_index, option_index, ...
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  result    | result_valid (strobe)   | status, result_block, chosen_option, ...
//
// Load items leave busy low. A run item holds busy high for the whole search:
// a check step, then per visited node one mask/partial RAM read per word, a
// drain step and a decide step, plus an advance or backtrack step when one is
// taken, then the results. The single read port of each RAM sets the per-word
// pace. Reset is synchronous and clears control state and the option counts;
// no clearing pass is needed. Results cannot be stalled and appear as one-cycle
// strobes. Configuration writes are taken only while idle and no item is
// offered.
`timescale 1ns / 1ps
`default_nettype none
module disjoint_mask_tuple_search_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  block_index,
  input  wire logic [5:0]  option_index,
  input  wire logic [1:0]  word_index,
  input  wire logic [63:0] mask_word,
  input  wire logic [6:0]  opt_total,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output      logic        result_valid,
  output      logic [1:0]  status,
  output      logic [3:0]  result_block,
  output      logic [5:0]  chosen_option,
  output      logic [63:0] tuples_tested,
  output      logic        last
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_DECIDE, S_ADV, S_OUT
  } state_t;

  state_t state;

  logic [4:0] blk_cfg;
  logic [2:0] wrd_cfg;
  logic [dmts_pkg::CNT_W-1:0] opb [dmts_pkg::MAX_BLOCKS];
  logic [dmts_pkg::OPT_W-1:0] choice [dmts_pkg::MAX_BLOCKS];
  logic [dmts_pkg::LVL_W-1:0] lvl;
  logic [dmts_pkg::WRD_W:0]   iw;
  logic [dmts_pkg::WRD_W-1:0] pipe_w;
  logic                       pipe_v;
  logic                       any_acc;
  logic                       found;
  logic [1:0]                 out_st;
  logic [dmts_pkg::LVL_W-1:0] oi;
  logic [63:0]                tested;

  logic [dmts_pkg::NB_W-1:0]  nb;
  logic [dmts_pkg::WRD_W:0]   nw;
  logic                       any_empty;
  logic                       at_last_lvl;
  logic [dmts_pkg::CNT_W-1:0] nxt;
  logic [63:0]                mask_rdata;
  logic [63:0]                part_rdata;
  logic [63:0]                tmp;
  logic                       accept;
  logic                       load_we;
  logic [dmts_pkg::MASK_AW-1:0] mask_waddr;
  logic [dmts_pkg::MASK_AW-1:0] mask_raddr;
  logic [dmts_pkg::PART_AW-1:0] part_waddr;
  logic [dmts_pkg::PART_AW-1:0] part_raddr;
  logic [dmts_pkg::LVL_W-1:0]   lvl_prev;

  assign busy      = (state != S_IDLE);
  // Take register writes only while nothing is in flight
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign nb        = dmts_pkg::eff_blocks(blk_cfg);
  assign nw        = dmts_pkg::eff_words(wrd_cfg);
  assign at_last_lvl = ({1'b0, lvl} == nb - dmts_pkg::NB_W'(1));
  assign nxt       = {1'b0, choice[lvl]} + dmts_pkg::CNT_W'(1);
  assign lvl_prev  = lvl - dmts_pkg::LVL_W'(1);

  // Flag any used block that has no options
  always_comb begin
    any_empty = 1'b0;
    for (int i = 0; i < dmts_pkg::MAX_BLOCKS; i++) begin
      if ((dmts_pkg::NB_W'(i) < nb) && (opb[i] == '0)) any_empty = 1'b1;
    end
  end

  // Mask store: loads write, the search reads one word per cycle
  assign load_we    = accept && (opcode == dmts_pkg::OP_LOAD_MASK);
  assign mask_waddr = {block_index, option_index, word_index};
  assign mask_raddr = {lvl, choice[lvl], iw[dmts_pkg::WRD_W-1:0]};

  dmts_ram #(
    .WIDTH(64),
    .DEPTH(dmts_pkg::MAX_BLOCKS * dmts_pkg::MAX_OPTIONS * dmts_pkg::MAX_WORDS)
  ) u_mask_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(mask_waddr),
    .wdata(mask_word),
    .raddr(mask_raddr),
    .rdata(mask_rdata)
  );

  // Partial intersection stack: read level above, write current level
  assign tmp        = (lvl == '0) ? mask_rdata : (mask_rdata & part_rdata);
  assign part_waddr = {lvl, pipe_w};
  assign part_raddr = {lvl_prev, iw[dmts_pkg::WRD_W-1:0]};

  dmts_ram #(
    .WIDTH(64),
    .DEPTH(dmts_pkg::MAX_BLOCKS * dmts_pkg::MAX_WORDS)
  ) u_part_ram (
    .clk  (clk),
    .we   (pipe_v),
    .waddr(part_waddr),
    .wdata(tmp),
    .raddr(part_raddr),
    .rdata(part_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_cfg <= 5'd2;
      wrd_cfg <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == dmts_pkg::CFG_BLOCK_COUNT) blk_cfg <= cfg_data[4:0];
      else if (cfg_index == dmts_pkg::CFG_WORD_COUNT) wrd_cfg <= cfg_data[2:0];
    end
  end

  // Search sequencer, stacks and registered result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pipe_v       <= 1'b0;
      lvl          <= '0;
      tested       <= '0;
      for (int i = 0; i < dmts_pkg::MAX_BLOCKS; i++) begin
        opb[i]    <= '0;
        choice[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      pipe_v       <= (state == S_ISSUE);
      pipe_w       <= iw[dmts_pkg::WRD_W-1:0];
      if (pipe_v) any_acc <= any_acc | (|tmp);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == dmts_pkg::OP_SET_COUNT) begin
              opb[block_index] <= (opt_total > 7'(dmts_pkg::MAX_OPTIONS))
                                  ? dmts_pkg::CNT_W'(dmts_pkg::MAX_OPTIONS) : opt_total;
            end else if (opcode == dmts_pkg::OP_RUN) begin
              tested <= '0;
              state  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          oi <= '0;
          if (any_empty) begin
            out_st <= dmts_pkg::ST_EMPTY;
            found  <= 1'b0;
            state  <= S_OUT;
          end else begin
            for (int i = 0; i < dmts_pkg::MAX_BLOCKS; i++) choice[i] <= '0;
            lvl     <= '0;
            iw      <= '0;
            any_acc <= 1'b0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // issue one word read per cycle
          iw <= iw + 1'b1;
          if (iw == nw - 1'b1) state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          iw <= '0;
          any_acc <= 1'b0;
          if (lvl == '0) begin
            lvl       <= dmts_pkg::LVL_W'(1);
            choice[1] <= '0;
            state     <= S_ISSUE;
          end else if (at_last_lvl) begin
            if (tested != '1) tested <= tested + 64'd1;
            if (!any_acc) begin
              found  <= 1'b1;
              out_st <= dmts_pkg::ST_FEASIBLE;
              state  <= S_OUT;
            end else begin
              state <= S_ADV;
            end
          end else if (!any_acc) begin
            found  <= 1'b1;
            out_st <= dmts_pkg::ST_FEASIBLE;
            state  <= S_OUT;
          end else begin
            lvl                <= lvl + 1'b1;
            choice[lvl + 1'b1] <= '0;
            state              <= S_ISSUE;
          end
        end
        S_ADV: begin
          // advance the current choice, drop a level when it runs out (infeasible at level 0)
          if (nxt >= opb[lvl]) begin
            if (lvl == '0) begin
              found  <= 1'b0;
              out_st <= dmts_pkg::ST_INFEASIBLE;
              state  <= S_OUT;
            end else begin
              lvl <= lvl_prev;
            end
          end else begin
            choice[lvl] <= nxt[dmts_pkg::OPT_W-1:0];
            iw          <= '0;
            any_acc     <= 1'b0;
            state       <= S_ISSUE;
          end
        end
        S_OUT: begin
          result_valid  <= 1'b1;
          status        <= out_st;
          tuples_tested <= tested;
          result_block  <= found ? oi : '0;
          chosen_option <= (found && oi <= lvl) ? choice[oi] : '0;
          last          <= !found || ({1'b0, oi} == nb - dmts_pkg::NB_W'(1));
          if (!found || ({1'b0, oi} == nb - dmts_pkg::NB_W'(1))) state <= S_IDLE;
          else oi <= oi + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only leaves from a run state that is marked busy
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result outside a run");

  // Single results of a failed or invalid run close the run
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != dmts_pkg::ST_FEASIBLE) |-> last)
    else $error("non-feasible result not last");

  // An invalid problem reports no tested tuples
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dmts_pkg::ST_EMPTY) |-> (tuples_tested == '0))
    else $error("empty block result with nonzero count");

  // Word reads stay within the configured mask width
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (iw < nw))
    else $error("word read beyond mask width");

endmodule
`default_nettype wire

// ===== sv/dmts_ram.sv =====
// Simple dual port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dmts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
